/* src/tcw_pkg.sv */
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int TCW_COLUMNS = 80;
   localparam int TCW_ROWS    = 25;

   localparam int CMD_W    = 2;
   localparam int CHAR_W   = 8;
   localparam int INDEX_W  = 11;
   localparam int ENTRY_W  = 16;
   localparam int CROW_W   = 5;
   localparam int CCOL_W   = 7;
   localparam int OFFSET_W = 11;
   localparam int COLOR_W  = 8;

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;
   localparam logic [ENTRY_W-1:0] RESET_CELL   = {RESET_COLOR, SPACE_CODE};

   typedef enum logic [CMD_W-1:0] {
      OP_PUT   = 2'd0,
      OP_BREAK = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } tcw_op_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic exec;
      logic read_cell;
      logic sweep_clear;
      logic sweep_step;
      logic copy_read;
      logic fill_write;
      logic fill_init;
      logic home;
      logic load_out;
   } tcw_cmd_type;

   // datapath to controller
   typedef struct packed {
      tcw_op_type op;
      logic       pending;
      logic       at_bottom;
      logic       copy_end;
      logic       row_end;
      logic       all_end;
   } tcw_status_type;

endpackage

/* src/tcw_datapath.sv */
`timescale 1ns / 1ps

module tcw_datapath import tcw_pkg::*; #(
   parameter int COLUMNS = TCW_COLUMNS,
   parameter int ROWS    = TCW_ROWS
) (
   input  logic                clock,
   input  logic                reset,
   input  tcw_cmd_type         cmd,
   output tcw_status_type      status,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [INDEX_W-1:0]  req_cell_index,
   input  logic                csr_write_enable,
   input  logic [COLOR_W-1:0]  csr_write_data,
   output logic [ENTRY_W-1:0]  rsp_cell_entry,
   output logic [CROW_W-1:0]   rsp_cursor_row,
   output logic [CCOL_W-1:0]   rsp_cursor_col,
   output logic [OFFSET_W-1:0] rsp_cursor_offset
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int CMP_W      = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

   localparam logic [ROW_W-1:0]  ROW_BOTTOM = ROW_W'(ROWS - 2);
   localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'((ROWS - 2) * COLUMNS - 1);
   localparam logic [ADDR_W-1:0] BLANK_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
   localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELL_COUNT - 1);

   logic [ENTRY_W-1:0] mem [CELL_COUNT];
   logic [ENTRY_W-1:0] rdata_ff;

   tcw_op_type          op_ff;
   logic [CHAR_W-1:0]   char_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic                entry_use_ff;
   logic [COLOR_W-1:0]  color_ff;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   sweep_ff;
   logic                cp_wr_ff;
   logic [ADDR_W-1:0]   cp_addr_ff;
   logic [ENTRY_W-1:0]  out_entry_ff;
   logic [CROW_W-1:0]   out_row_ff;
   logic [CCOL_W-1:0]   out_col_ff;
   logic [OFFSET_W-1:0] out_offset_ff;

   logic [ROW_W-1:0]   eff_row;
   logic [COL_W-1:0]   eff_col;
   logic               put_wr;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] fill_value;
   logic               idx_in_range;

   // a pending break resolves to the next row, or stays on the bottom text row
   assign eff_row = pend_ff ? ((row_ff == ROW_BOTTOM) ? row_ff : row_ff + 1'b1) : row_ff;
   assign eff_col = pend_ff ? '0 : col_ff;

   assign idx_in_range = CMP_W'(req_cell_index) < CMP_W'(CELL_COUNT);
   assign fill_value   = cmd.fill_init ? RESET_CELL : {color_ff, SPACE_CODE};
   assign put_wr       = cmd.exec && (op_ff == OP_PUT) && (char_ff != NEWLINE_CODE);

   always_comb begin
      wr_en   = cp_wr_ff || cmd.fill_write || put_wr;
      wr_addr = ADDR_W'(eff_row) * ROW_STRIDE + ADDR_W'(eff_col);
      wr_data = {color_ff, char_ff};
      priority if (cp_wr_ff) begin
         wr_addr = cp_addr_ff;
         wr_data = rdata_ff;
      end else if (cmd.fill_write) begin
         wr_addr = sweep_ff;
         wr_data = fill_value;
      end
   end

   assign rd_en   = cmd.copy_read || cmd.read_cell;
   assign rd_addr = cmd.copy_read ? sweep_ff + ROW_STRIDE : ADDR_W'(idx_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      pend_in = pend_ff;
      if (cmd.home) begin
         row_in  = '0;
         col_in  = '0;
         pend_in = 1'b0;
      end else if (cmd.exec) begin
         row_in  = eff_row;
         col_in  = eff_col;
         pend_in = 1'b1;
         if (put_wr) begin
            if (eff_col == COL_LAST) begin
               col_in = '0;
            end else begin
               col_in  = eff_col + 1'b1;
               pend_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= RESET_COLOR;
         row_ff   <= '0;
         col_ff   <= '0;
         pend_ff  <= 1'b0;
         sweep_ff <= '0;
         cp_wr_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            color_ff <= csr_write_data;
         end
         row_ff   <= row_in;
         col_ff   <= col_in;
         pend_ff  <= pend_in;
         cp_wr_ff <= cmd.copy_read;
         if (cmd.sweep_clear) begin
            sweep_ff <= '0;
         end else if (cmd.sweep_step) begin
            sweep_ff <= sweep_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cp_addr_ff <= sweep_ff;
      if (cmd.take) begin
         op_ff        <= tcw_op_type'(req_cmd);
         char_ff      <= req_char_code;
         idx_ff       <= req_cell_index;
         entry_use_ff <= (tcw_op_type'(req_cmd) == OP_READ) && idx_in_range;
      end
      if (cmd.load_out) begin
         out_entry_ff  <= entry_use_ff ? rdata_ff : '0;
         out_row_ff    <= CROW_W'(row_ff);
         out_col_ff    <= CCOL_W'(col_ff);
         out_offset_ff <= OFFSET_W'(ADDR_W'(row_ff) * ROW_STRIDE + ADDR_W'(col_ff));
      end
   end

   assign status.op        = op_ff;
   assign status.pending   = pend_ff;
   assign status.at_bottom = (row_ff == ROW_BOTTOM);
   assign status.copy_end  = (sweep_ff == COPY_LAST);
   assign status.row_end   = (sweep_ff == BLANK_LAST);
   assign status.all_end   = (sweep_ff == CELL_LAST);

   assign rsp_cell_entry    = out_entry_ff;
   assign rsp_cursor_row    = out_row_ff;
   assign rsp_cursor_col    = out_col_ff;
   assign rsp_cursor_offset = out_offset_ff;

endmodule

/* src/tcw_ctrl.sv */
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  tcw_status_type status,
   output tcw_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_COPY,
      ST_DRAIN,
      ST_BLANK,
      ST_ACT,
      ST_CLEAR
   } state_type;

   state_type state_ff, state_in;
   logic      res_pend_ff, res_pend_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      res_pend_in = res_pend_ff;
      req_stall   = 1'b1;
      accept      = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.fill_write = 1'b1;
            cmd.fill_init  = 1'b1;
            cmd.sweep_step = 1'b1;
            if (status.all_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // hand the finished cursor to the output register, take the next transfer
            req_stall = res_pend_ff && !out_free;
            if (res_pend_ff && out_free) begin
               cmd.load_out = 1'b1;
               res_pend_in  = 1'b0;
            end
            accept = req_valid && !req_stall;
            if (accept) begin
               cmd.take = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (status.op)
               OP_PUT, OP_BREAK: begin
                  if (status.pending && status.at_bottom) begin
                     cmd.sweep_clear = 1'b1;
                     state_in        = ST_COPY;
                  end else begin
                     cmd.exec    = 1'b1;
                     res_pend_in = 1'b1;
                     state_in    = ST_IDLE;
                  end
               end
               OP_CLEAR: begin
                  cmd.sweep_clear = 1'b1;
                  state_in        = ST_CLEAR;
               end
               OP_READ: begin
                  cmd.read_cell = 1'b1;
                  res_pend_in   = 1'b1;
                  state_in      = ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_COPY: begin
            cmd.copy_read  = 1'b1;
            cmd.sweep_step = 1'b1;
            if (status.copy_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last row copy lands this cycle
            state_in = ST_BLANK;
         end
         ST_BLANK: begin
            cmd.fill_write = 1'b1;
            cmd.sweep_step = 1'b1;
            if (status.row_end) begin
               state_in = ST_ACT;
            end
         end
         ST_ACT: begin
            cmd.exec    = 1'b1;
            res_pend_in = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_CLEAR: begin
            cmd.fill_write = 1'b1;
            cmd.sweep_step = 1'b1;
            if (status.all_end) begin
               cmd.home    = 1'b1;
               res_pend_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
      rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         res_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_pend_ff  <= res_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* src/text_console_char_writer_unit.sv */
`timescale 1ns / 1ps

// Text console writer: a ROWS x COLUMNS store of 16-bit cells (colour high, character low).
// Request channel (req_valid/req_stall) carries one command per transfer: put a character,
// break the line, clear the screen, or read the cell at req_cell_index. Each command returns
// exactly one response transfer on rsp_valid/rsp_stall with the cell read (zero unless an
// in-range read) and the cursor row, column and offset after the command.
// csr_write_enable/csr_write_data set the colour byte for new and blanked cells; write it
// only while no command is in flight.
// Commands are accepted only in the idle state, so a new command waits until the previous
// one has executed. A scroll (break past the bottom text row) copies the text rows through
// the single memory read port one cell per cycle. Clear writes every cell.
// Reset (synchronous) homes the cursor and runs a clearing pass over every cell that fills
// grey spaces; req_stall stays high meanwhile.
// The output register holds a response while rsp_stall is high; one further command may be
// accepted meanwhile, and its response waits until the register frees.
module text_console_char_writer_unit import tcw_pkg::*; #(
   parameter int COLUMNS = TCW_COLUMNS,
   parameter int ROWS    = TCW_ROWS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [INDEX_W-1:0]  req_cell_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ENTRY_W-1:0]  rsp_cell_entry,
   output logic [CROW_W-1:0]   rsp_cursor_row,
   output logic [CCOL_W-1:0]   rsp_cursor_col,
   output logic [OFFSET_W-1:0] rsp_cursor_offset,
   input  logic                csr_write_enable,
   input  logic [COLOR_W-1:0]  csr_write_data
);

   tcw_cmd_type    cmd;
   tcw_status_type status;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_cmd           (req_cmd),
      .req_char_code     (req_char_code),
      .req_cell_index    (req_cell_index),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_cell_entry    (rsp_cell_entry),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_cursor_offset (rsp_cursor_offset)
   );

endmodule

/* src/tcw_checker.sv */
`timescale 1ns / 1ps

module tcw_checker import tcw_pkg::*; #(
   parameter int COLUMNS = TCW_COLUMNS,
   parameter int ROWS    = TCW_ROWS
) (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [ENTRY_W-1:0]  rsp_cell_entry,
   input logic [CROW_W-1:0]   rsp_cursor_row,
   input logic [CCOL_W-1:0]   rsp_cursor_col,
   input logic [OFFSET_W-1:0] rsp_cursor_offset
);

   // cursor fields only carry the full value while the screen fits their widths
   localparam bit FITS = (ROWS <= 32) && (COLUMNS <= 128);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_entry)
                                 && $stable(rsp_cursor_offset))
      else $error("response changed while stalled");

   a_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && FITS |->
         rsp_cursor_offset == OFFSET_W'(rsp_cursor_row * COLUMNS + rsp_cursor_col))
      else $error("cursor offset disagrees with row and column");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && FITS |-> (rsp_cursor_row <= ROWS - 2) && (rsp_cursor_col < COLUMNS))
      else $error("cursor outside the text area");

   a_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall && !rsp_valid)
      else $error("transfer possible during the clearing pass");

endmodule

bind text_console_char_writer_unit tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_cell_entry    (rsp_cell_entry),
   .rsp_cursor_row    (rsp_cursor_row),
   .rsp_cursor_col    (rsp_cursor_col),
   .rsp_cursor_offset (rsp_cursor_offset)
);
